// ----- design/nagu_pkg.sv -----
`default_nettype none

package nagu_pkg;

    // Default number of fraction bits of every fixed-point word.
    localparam int FRAC_BITS_DEF = 16;

    // Width of the adaptation rate registers.
    localparam int RATE_W = 21;

    // One input word.
    typedef struct packed {
        logic signed [31:0] state_one;
        logic signed [31:0] state_two;
        logic signed [31:0] reference;
    } nagu_in_t;

    // One result word.
    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] augmented_error;
        logic signed [31:0] gain_state_one;
        logic signed [31:0] gain_state_two;
        logic signed [31:0] gain_reference;
        logic signed [31:0] gain_auxiliary;
    } nagu_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } nagu_state_t;

    // Product steps, in the order they run.
    typedef enum logic [4:0] {
        OP_U1, OP_U2, OP_U3,
        OP_X1, OP_X2, OP_X3,
        OP_E,
        OP_M1, OP_M2, OP_M3, OP_M4,
        OP_T1, OP_G1,
        OP_T2, OP_G2,
        OP_TR, OP_GR,
        OP_TA, OP_GA
    } nagu_op_t;

    // Sign extension of a 32-bit word to the wide working width.
    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    // Saturation of a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit word as an unsigned 32-bit word.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = $unsigned(v);
        return v[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

`default_nettype wire

// ----- design/normalized_adaptive_gain_update_core.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data   (nagu_in_t)
// out       output     out_valid/ out_stall out_data  (nagu_out_t)
// cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// From acceptance to the result register a word passes through nineteen products
// on one bit-serial shift-add multiplier, a restoring divider that yields one
// quotient bit per cycle, a step that settles the quotient, and a load of the
// result register, which waits until that register is free.
// A new word is taken once the previous one has moved to the result register,
// even while that result is still stalled. Reset loads the gains, the previous
// samples and the rates with their initial values.

module normalized_adaptive_gain_update_core
    import nagu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire nagu_in_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output nagu_out_t              out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [RATE_W-1:0] cfg_data
);

    // Widths of the divider and of the step counter.
    localparam int DW = 32 + FRAC_BITS;
    localparam int MW = 66 - FRAC_BITS;
    localparam int CW = 6;

    localparam logic [CW-1:0] MUL_LAST = CW'(31);
    localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

    // Reset values, rounded to nearest.
    localparam longint RATE_MAX = (64'sd1 <<< RATE_W) - 64'sd1;
    localparam longint R1_RAW = ((64'sd6 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam longint R2_RAW = ((64'sd8 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam longint RR_RAW = ((64'sd10 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam longint RA_RAW = ((64'sd12 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam logic [RATE_W-1:0] R1_RST = RATE_W'((R1_RAW > RATE_MAX) ? RATE_MAX : R1_RAW);
    localparam logic [RATE_W-1:0] R2_RST = RATE_W'((R2_RAW > RATE_MAX) ? RATE_MAX : R2_RAW);
    localparam logic [RATE_W-1:0] RR_RST = RATE_W'((RR_RAW > RATE_MAX) ? RATE_MAX : RR_RAW);
    localparam logic [RATE_W-1:0] RA_RST = RATE_W'((RA_RAW > RATE_MAX) ? RATE_MAX : RA_RAW);
    localparam logic signed [31:0] X1P_RST =
        32'(((64'sd26 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] X2P_RST =
        32'(((64'sd4 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] RP_RST =
        32'(((64'sd32 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [65:0] ONE66 = 66'sd1 <<< FRAC_BITS;
    localparam logic [DW-1:0] QMAX = DW'(33'h0_7FFF_FFFF);
    localparam logic [DW-1:0] QMIN_MAG = DW'(33'h0_8000_0000);

    nagu_state_t state_reg, state_next;
    nagu_op_t    op_reg;
    logic [CW-1:0] cnt_reg;

    logic [RATE_W-1:0] rate1_reg, rate2_reg, rater_reg, ratea_reg;
    logic signed [31:0] x1p_reg, x2p_reg, rp_reg;
    logic signed [31:0] k1_reg, k2_reg, kr_reg, kp_reg;
    logic signed [31:0] o1_reg, o2_reg, or_reg;
    nagu_in_t in_reg;

    logic signed [31:0] u_reg, xi_reg, eps_reg, t_reg, n_reg;
    logic signed [65:0] acc_reg;
    logic [MW-1:0] m_reg;

    logic [31:0] ma_reg;
    logic [63:0] prod_reg;
    logic        neg_reg;

    logic [DW-1:0] div_reg;
    logic [MW-1:0] rem_reg;

    logic      out_valid_reg;
    nagu_out_t out_reg;

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Gain changes since the previous step.
    logic signed [31:0] d1, d2, dr;
    assign d1 = sat32(sx66(k1_reg) - sx66(o1_reg));
    assign d2 = sat32(sx66(k2_reg) - sx66(o2_reg));
    assign dr = sat32(sx66(kr_reg) - sx66(or_reg));

    // Operand selection for the current product step.
    logic signed [31:0] opa, opb;
    always_comb
    begin
        case (op_reg)
            OP_U1:   begin opa = k1_reg; opb = in_reg.state_one; end
            OP_U2:   begin opa = k2_reg; opb = in_reg.state_two; end
            OP_U3:   begin opa = kr_reg; opb = in_reg.reference; end
            OP_X1:   begin opa = d1;     opb = x1p_reg;          end
            OP_X2:   begin opa = d2;     opb = x2p_reg;          end
            OP_X3:   begin opa = dr;     opb = rp_reg;           end
            OP_E:    begin opa = kp_reg; opb = xi_reg;           end
            OP_M1:   begin opa = x1p_reg; opb = x1p_reg;         end
            OP_M2:   begin opa = x2p_reg; opb = x2p_reg;         end
            OP_M3:   begin opa = rp_reg; opb = rp_reg;           end
            OP_M4:   begin opa = xi_reg; opb = xi_reg;           end
            OP_T1:   begin opa = 32'(rate1_reg); opb = x1p_reg;  end
            OP_T2:   begin opa = 32'(rate2_reg); opb = x2p_reg;  end
            OP_TR:   begin opa = 32'(rater_reg); opb = rp_reg;   end
            OP_TA:   begin opa = 32'(ratea_reg); opb = xi_reg;   end
            default: begin opa = t_reg;  opb = n_reg;            end
        endcase
    end

    // Multiplier step: add the multiplicand on a set bit, shift right.
    logic [32:0] mul_sum;
    logic [63:0] prod_next;
    assign mul_sum   = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, ma_reg} : 33'd0);
    assign prod_next = {mul_sum, prod_reg[31:1]};

    // Signed product, floored by the fraction width.
    logic signed [64:0] prod_s, prod_fl;
    logic signed [65:0] f66, sum66;
    assign prod_s  = neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign prod_fl = prod_s >>> FRAC_BITS;
    assign f66     = {prod_fl[64], prod_fl};
    assign sum66   = acc_reg + f66;

    // Divider step: shift one dividend bit into the remainder, subtract if it fits.
    logic [MW:0]   rem_sh, rem_diff;
    logic          q_bit;
    assign rem_sh   = {rem_reg, div_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, m_reg};
    assign q_bit    = (rem_sh >= {1'b0, m_reg});

    // Signed, saturated quotient.
    logic signed [31:0] n_val;
    logic [DW-1:0]      q_neg;
    assign q_neg = ~div_reg + DW'(1);
    always_comb
    begin
        if (neg_reg) begin
            n_val = (div_reg > QMIN_MAG) ? 32'sh8000_0000 : $signed(q_neg[31:0]);
        end else begin
            n_val = (div_reg > QMAX) ? 32'sh7FFF_FFFF : $signed(div_reg[31:0]);
        end
    end

    logic [31:0] eps_mag;
    assign eps_mag = mag32(eps_reg);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == MUL_LAST) state_next = ST_POST;
            ST_POST:
            begin
                if (op_reg == OP_M4) begin
                    state_next = ST_DIV;
                end else if (op_reg == OP_GA) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_NORM;
            ST_NORM: state_next = ST_LOAD;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_reg        <= OP_U1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rate1_reg     <= R1_RST;
            rate2_reg     <= R2_RST;
            rater_reg     <= RR_RST;
            ratea_reg     <= RA_RST;
            x1p_reg       <= X1P_RST;
            x2p_reg       <= X2P_RST;
            rp_reg        <= RP_RST;
            k1_reg        <= '0;
            k2_reg        <= '0;
            kr_reg        <= '0;
            kp_reg        <= '0;
            o1_reg        <= '0;
            o2_reg        <= '0;
            or_reg        <= '0;
        end else begin
            // Rate register writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    2'd0:    rate1_reg <= cfg_data;
                    2'd1:    rate2_reg <= cfg_data;
                    2'd2:    rater_reg <= cfg_data;
                    default: ratea_reg <= cfg_data;
                endcase
            end

            // The result register fills when free and empties when taken.
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    op_reg <= OP_U1;
                end
                ST_LOAD:
                begin
                    cnt_reg <= '0;
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_POST:
                begin
                    cnt_reg <= '0;
                    op_reg  <= nagu_op_t'(op_reg + 5'd1);
                    // Gain updates; the old gains keep the values before the step.
                    case (op_reg)
                        OP_G1:
                        begin
                            o1_reg <= k1_reg;
                            k1_reg <= sat32(sx66(k1_reg) - sx66(sat32(f66)));
                        end
                        OP_G2:
                        begin
                            o2_reg <= k2_reg;
                            k2_reg <= sat32(sx66(k2_reg) - sx66(sat32(f66)));
                        end
                        OP_GR:
                        begin
                            or_reg <= kr_reg;
                            kr_reg <= sat32(sx66(kr_reg) - sx66(sat32(f66)));
                        end
                        OP_GA:
                        begin
                            kp_reg <= sat32(sx66(kp_reg) - sx66(sat32(f66)));
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_DONE:
                begin
                    if (out_free) begin
                        x1p_reg       <= in_reg.state_one;
                        x2p_reg       <= in_reg.state_two;
                        rp_reg        <= in_reg.reference;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    in_reg <= in_data;
                end
            end
            ST_LOAD:
            begin
                ma_reg   <= mag32(opa);
                prod_reg <= {32'd0, mag32(opb)};
                neg_reg  <= opa[31] ^ opb[31];
            end
            ST_MUL:
            begin
                prod_reg <= prod_next;
            end
            ST_POST:
            begin
                case (op_reg)
                    OP_U1, OP_X1: acc_reg <= f66;
                    OP_M1:        acc_reg <= f66 + ONE66;
                    OP_U2, OP_X2, OP_M2, OP_M3: acc_reg <= sum66;
                    OP_U3:        u_reg   <= sat32(sum66);
                    OP_X3:        xi_reg  <= sat32(sum66);
                    OP_E:
                    begin
                        eps_reg <= sat32(sx66(in_reg.state_one) - sx66(rp_reg) + f66);
                    end
                    OP_M4:
                    begin
                        m_reg   <= sum66[MW-1:0];
                        div_reg <= {eps_mag, {FRAC_BITS{1'b0}}};
                        rem_reg <= '0;
                        neg_reg <= eps_reg[31];
                    end
                    OP_T1, OP_T2, OP_TR, OP_TA: t_reg <= sat32(f66);
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_reg <= q_bit ? rem_diff[MW-1:0] : rem_sh[MW-1:0];
                div_reg <= {div_reg[DW-2:0], q_bit};
            end
            ST_NORM:
            begin
                n_reg <= n_val;
            end
            ST_DONE:
            begin
                if (out_free) begin
                    out_reg.drive           <= u_reg;
                    out_reg.augmented_error <= eps_reg;
                    out_reg.gain_state_one  <= k1_reg;
                    out_reg.gain_state_two  <= k2_reg;
                    out_reg.gain_reference  <= kr_reg;
                    out_reg.gain_auxiliary  <= kp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- bench/normalized_adaptive_gain_update_core_tb.sv -----
module normalized_adaptive_gain_update_core_tb;
    import nagu_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 681 + FB + 8;

    // Register indexes of the adaptation rates.
    localparam logic [1:0] REG_RATE_ONE = 2'd0;
    localparam logic [1:0] REG_RATE_TWO = 2'd1;
    localparam logic [1:0] REG_RATE_REF = 2'd2;
    localparam logic [1:0] REG_RATE_AUX = 2'd3;

    localparam longint LIMIT_CYCLES = 4000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    nagu_in_t in_data;
    logic out_valid;
    logic out_stall;
    nagu_out_t out_data;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [RATE_W-1:0] cfg_data;

    normalized_adaptive_gain_update_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: rates, previous samples and gains.
    logic [RATE_W-1:0] rate_one, rate_two, rate_ref, rate_aux;
    longint prev_x1, prev_x2, prev_r;
    longint gain_one, gain_two, gain_ref, gain_aux;
    longint held_one, held_two, held_ref;

    nagu_in_t  word_queue[$];
    nagu_out_t result_queue[$];
    int error_count;
    int result_count;
    longint cycle_count;
    bit quiet_phase;
    int hold_off;
    bit in_accepted;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Fixed-point product, floored.
    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint adapt(input longint g, input longint rate,
                                     input longint sample, input longint n);
        longint t;
        longint d;
        t = clip32(fmul(rate, sample));
        d = clip32(fmul(t, n));
        return clip32(g - d);
    endfunction

    function automatic longint tenths(input longint t);
        return ((t <<< FB) + 5) / 10;
    endfunction

    function automatic logic [RATE_W-1:0] rate_init(input longint t);
        longint v;
        v = tenths(t);
        if (v > (2 ** RATE_W) - 1) v = (2 ** RATE_W) - 1;
        return v[RATE_W-1:0];
    endfunction

    task automatic reset_predictor();
        rate_one = rate_init(6);
        rate_two = rate_init(8);
        rate_ref = rate_init(10);
        rate_aux = rate_init(12);
        prev_x1 = tenths(26);
        prev_x2 = tenths(4);
        prev_r = tenths(32);
        gain_one = 0; gain_two = 0; gain_ref = 0; gain_aux = 0;
        held_one = 0; held_two = 0; held_ref = 0;
    endtask

    // Computes the expected result of one gain update and advances the state.
    task automatic predict_update(input nagu_in_t w);
        longint x1, x2, r, u, xi, eps, m, n;
        nagu_out_t res;
        x1 = longint'(w.state_one);
        x2 = longint'(w.state_two);
        r = longint'(w.reference);
        u = clip32(fmul(gain_one, x1) + fmul(gain_two, x2) + fmul(gain_ref, r));
        xi = clip32(fmul(clip32(gain_one - held_one), prev_x1)
                    + fmul(clip32(gain_two - held_two), prev_x2)
                    + fmul(clip32(gain_ref - held_ref), prev_r));
        eps = clip32((x1 - prev_r) + fmul(gain_aux, xi));
        m = (64'sd1 <<< FB) + fmul(prev_x1, prev_x1) + fmul(prev_x2, prev_x2)
            + fmul(prev_r, prev_r) + fmul(xi, xi);
        n = clip32((eps * (64'sd1 <<< FB)) / m);
        held_one = gain_one; held_two = gain_two; held_ref = gain_ref;
        gain_one = adapt(gain_one, longint'(rate_one), prev_x1, n);
        gain_two = adapt(gain_two, longint'(rate_two), prev_x2, n);
        gain_ref = adapt(gain_ref, longint'(rate_ref), prev_r, n);
        gain_aux = adapt(gain_aux, longint'(rate_aux), xi, n);
        prev_x1 = x1; prev_x2 = x2; prev_r = r;
        res.drive = u[31:0];
        res.augmented_error = eps[31:0];
        res.gain_state_one = gain_one[31:0];
        res.gain_state_two = gain_two[31:0];
        res.gain_reference = gain_ref[31:0];
        res.gain_auxiliary = gain_aux[31:0];
        result_queue.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch on result %0d: %s got %h expected %h",
                 result_count, what, got, want);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("normalized_adaptive_gain_update_core_tb: done, errors");
            $finish;
        end
    end

    // Records at each rising edge whether the offered word was taken.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_valid && !in_stall;
    end

    // Driver: offers queued words, with random gaps.
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_accepted)
            begin
                void'(word_queue.pop_front());
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (word_queue.size() > 0)
            begin
                in_data <= word_queue[0];
                in_valid <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: random bursts, plus a long hold-off when asked.
    int stall_left;
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end else
            out_stall <= 1'b0;
    end

    // Monitor: predicts accepted words and checks results.
    always @(posedge clk)
    begin
        nagu_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_update(in_data);
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    report_mismatch("unexpected result word, drive", out_data.drive,
                                    32'd0);
                end else
                begin
                    want = result_queue.pop_front();
                    if (out_data.drive !== want.drive)
                        report_mismatch("drive", out_data.drive, want.drive);
                    if (out_data.augmented_error !== want.augmented_error)
                        report_mismatch("augmented_error", out_data.augmented_error,
                                        want.augmented_error);
                    if (out_data.gain_state_one !== want.gain_state_one)
                        report_mismatch("gain_state_one", out_data.gain_state_one,
                                        want.gain_state_one);
                    if (out_data.gain_state_two !== want.gain_state_two)
                        report_mismatch("gain_state_two", out_data.gain_state_two,
                                        want.gain_state_two);
                    if (out_data.gain_reference !== want.gain_reference)
                        report_mismatch("gain_reference", out_data.gain_reference,
                                        want.gain_reference);
                    if (out_data.gain_auxiliary !== want.gain_auxiliary)
                        report_mismatch("gain_auxiliary", out_data.gain_auxiliary,
                                        want.gain_auxiliary);
                end
                result_count++;
            end
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
        endcase
    endfunction

    function automatic nagu_in_t rand_word();
        nagu_in_t w;
        w.state_one = rand_sample();
        w.state_two = rand_sample();
        w.reference = rand_sample();
        return w;
    endfunction

    task automatic drain();
        while (word_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Writes one rate register at a falling edge; the predictor follows at the write edge.
    task automatic write_rate(input logic [1:0] idx, input logic [RATE_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_RATE_ONE: rate_one = val;
            REG_RATE_TWO: rate_two = val;
            REG_RATE_REF: rate_ref = val;
            default: rate_aux = val;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] b,
                             input logic [RATE_W-1:0] c, input logic [RATE_W-1:0] d);
        write_rate(REG_RATE_ONE, a);
        write_rate(REG_RATE_TWO, b);
        write_rate(REG_RATE_REF, c);
        write_rate(REG_RATE_AUX, d);
    endtask

    // Stimulus.
    initial
    begin
        nagu_in_t w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_RATE_ONE;
        cfg_data = '0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        hold_off = 0;
        send_gap = 0;
        stall_left = 0;
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset rates: zeros, extremes, small values.
        word_queue.push_back('0);
        word_queue.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        word_queue.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        word_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000});
        word_queue.push_back('{32'sh0001_0000, 32'sh0000_8000, -32'sh0001_0000});
        word_queue.push_back('{-32'sd1, 32'sd1, -32'sd1});
        word_queue.push_back('{32'sh0002_0000, -32'sh0003_0000, 32'sh0000_4000});
        drain();

        // Extreme rates, then zero rates.
        set_rates('1, '1, '1, '1);
        for (int i = 0; i < 10; i++)
        begin
            w.state_one = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            w.state_two = (i % 3) ? 32'sh0004_0000 : -32'sh0004_0000;
            w.reference = rand_sample();
            word_queue.push_back(w);
        end
        drain();
        set_rates('0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
            word_queue.push_back(rand_word());
        drain();

        // Long receiver hold-off while words keep coming, so the block backs up.
        set_rates(21'd65536, 21'd32768, 21'd1048576, 21'd13107);
        hold_off = 3 * LATENCY;
        for (int i = 0; i < 8; i++)
            word_queue.push_back(rand_word());
        drain();

        // Random phases under random rates; the last phase has no idling.
        for (int p = 0; p < 6; p++)
        begin
            set_rates(RATE_W'($urandom_range(0, 1048576)),
                      RATE_W'($urandom_range(0, 1048576)),
                      RATE_W'($urandom()),
                      RATE_W'($urandom_range(0, 1048576)));
            if (p == 5)
                quiet_phase = 1'b1;
            for (int i = 0; i < 105; i++)
                word_queue.push_back(rand_word());
            drain();
        end

        $display("covered %0d result words across reset, extreme, zero and random rates",
                 result_count);
        $display("including a long output hold-off that backed up the input");
        if (error_count == 0)
            $display("normalized_adaptive_gain_update_core_tb: done, clean");
        else
            $display("normalized_adaptive_gain_update_core_tb: done, errors");
        $finish;
    end
endmodule

// ----- files.f -----
design/nagu_pkg.sv
design/normalized_adaptive_gain_update_core.sv
bench/normalized_adaptive_gain_update_core_tb.sv
